@@ rtl/srtf_preemptive_scheduler_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the shortest-remaining-time-first scheduler
// Shared property shapes for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef SRTF_PREEMPTIVE_SCHEDULER_MACROS_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRTF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/srtf_pkg.sv @@
// ----------------------------------------------------------------------------
// srtf_pkg
// Types and codes shared by the scheduler modules.
// ----------------------------------------------------------------------------
package srtf_pkg;

	// Request kinds.
	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_ZERO      = 2'd2;
	localparam logic [1:0] ST_IDLE_TICK = 2'd3;

	typedef struct packed {
		logic        func;
		logic [15:0] burst;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  job_slot;
		logic        ran;
		logic        finished;
		logic [31:0] current_time;
		logic [31:0] turnaround;
		logic [31:0] waiting;
		logic [47:0] total_turnaround;
		logic [47:0] total_waiting;
		logic [15:0] completed_count;
	} rsp_t;

	// One job table entry as held in the job memory.
	typedef struct packed {
		logic [15:0] rem;
		logic [15:0] burst;
		logic [31:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Running best candidate of a selection scan.
	typedef struct packed {
		logic        found;
		logic [15:0] rem;
		logic [31:0] age;
	} best_t;

endpackage

@@ rtl/srtf_ram.sv @@
// ----------------------------------------------------------------------------
// srtf_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module srtf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/srtf_pick.sv @@
// ----------------------------------------------------------------------------
// srtf_pick
// Shared compare unit: decides whether a table entry beats the current best.
// ----------------------------------------------------------------------------
module srtf_pick (
	input  logic             cand_valid,
	input  srtf_pkg::entry_t cand,
	input  logic [31:0]      time_now,
	input  srtf_pkg::best_t  best,
	output logic             take,
	output srtf_pkg::best_t  cand_best
);

	logic [31:0] age;

	// Age is taken modulo 2^32 so that ordering survives a wrap of the clock.
	assign age = time_now - cand.stamp;

	assign take = cand_valid && (!best.found || (cand.rem < best.rem) ||
		((cand.rem == best.rem) && (age > best.age)));

	always_comb begin
		cand_best.found = 1'b1;
		cand_best.rem   = cand.rem;
		cand_best.age   = age;
	end

endmodule

@@ rtl/srtf_preemptive_scheduler.sv @@
// ----------------------------------------------------------------------------
// srtf_preemptive_scheduler
// Event-driven preemptive shortest-remaining-time-first job scheduler.
// ----------------------------------------------------------------------------
// Usage: requests come in on req (req_valid / req_stall), one result beat per
// request leaves on rsp (rsp_valid / rsp_stall). An arrive beat (func = 0)
// places a job in the lowest free slot; a tick beat (func = 1) runs one time
// unit of the job with the least remaining time and reports its completion.
// Flow: a zero-burst arrive goes straight to its result. An arrive scans
// the slot valid bits one per cycle up to the first free slot, or to the
// last slot when the table is full. A tick reads the job memory one slot
// per cycle through the shared compare unit, then runs the chosen job; a
// finished job adds the waiting-time and totals steps. One request at a
// time: req_stall stays high until the result is handed to the output
// register. The output register lets a new request start while the previous
// result beat is still stalled; a finished result then waits in its state
// until the output register frees up. At reset all slots are empty, time and
// the totals are zero; the job memory itself is not cleared because only
// entries of slots marked valid are ever used.
// ----------------------------------------------------------------------------
`include "srtf_preemptive_scheduler_macros.svh"

module srtf_preemptive_scheduler #(
	parameter int MAX_JOBS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  srtf_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output srtf_pkg::rsp_t  rsp
);

	localparam int IW = $clog2(MAX_JOBS);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_JOBS - 1);

	// Sequencer states, one-hot.
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,  // waiting for a request
		S_ASCAN  = 8'b0000_0010,  // arrive: looking for a free slot
		S_TSCAN  = 8'b0000_0100,  // tick: issuing memory reads per slot
		S_TLAST  = 8'b0000_1000,  // tick: final compare of the last slot
		S_UPDATE = 8'b0001_0000,  // tick: run the chosen job one unit
		S_CALC   = 8'b0010_0000,  // finished job: waiting time
		S_ACCUM  = 8'b0100_0000,  // finished job: running totals
		S_RESULT = 8'b1000_0000   // hand the result to the output register
	} state_t;

	state_t state_q;

	// Control state.
	logic [IW-1:0]       idx_q;
	logic [MAX_JOBS-1:0] slot_valid_q;
	logic [31:0]         time_now_q;
	logic [47:0]         sum_tat_q;
	logic [47:0]         sum_wt_q;
	logic [15:0]         done_cnt_q;
	logic                rsp_valid_q;

	// Scan pipeline: the memory read data arrives in the cycle after the address.
	logic                cmp_en_s1;
	logic                vld_s1;
	logic [IW-1:0]       idx_s1;

	// Best candidate of the current tick scan.
	srtf_pkg::best_t     best_q;
	logic [IW-1:0]       best_idx_q;
	logic [15:0]         best_burst_q;
	logic [31:0]         best_stamp_q;

	// Working registers of the request in flight.
	logic [15:0]         burst_q;
	logic [1:0]          res_status_q;
	logic [IW-1:0]       res_slot_q;
	logic                res_ran_q;
	logic                res_fin_q;
	logic [31:0]         res_tat_q;
	logic [31:0]         res_wt_q;
	srtf_pkg::rsp_t      rsp_q;

	// Job memory and compare unit.
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	srtf_pkg::entry_t    ram_wentry;
	logic [srtf_pkg::ENTRY_W-1:0] ram_rdata;
	srtf_pkg::entry_t    rd_entry;
	logic                take;
	srtf_pkg::best_t     cand_best;
	logic                slot_free;
	logic [48:0]         tat_sum;
	logic [48:0]         wt_sum;
	logic                rsp_load;

	assign slot_free = !slot_valid_q[idx_q];

	// The output register takes a new result when it is empty or its beat
	// leaves in this cycle.
	assign rsp_load = (state_q == S_RESULT) && (!rsp_valid_q || !rsp_stall);

	// The job memory is written when an arrive claims a slot and when a tick
	// charges one time unit to the selected job.
	always_comb begin
		ram_we           = 1'b0;
		ram_waddr        = idx_q;
		ram_wentry.rem   = burst_q;
		ram_wentry.burst = burst_q;
		ram_wentry.stamp = time_now_q;
		case (state_q)
			S_ASCAN: begin
				ram_we = slot_free;
			end
			S_UPDATE: begin
				ram_we           = best_q.found;
				ram_waddr        = best_idx_q;
				ram_wentry.rem   = best_q.rem - 16'd1;
				ram_wentry.burst = best_burst_q;
				ram_wentry.stamp = best_stamp_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	srtf_ram #(
		.WIDTH (srtf_pkg::ENTRY_W),
		.DEPTH (MAX_JOBS)
	) u_job_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign rd_entry = ram_rdata;

	srtf_pick u_pick (
		.cand_valid (cmp_en_s1 && vld_s1),
		.cand       (rd_entry),
		.time_now   (time_now_q),
		.best       (best_q),
		.take       (take),
		.cand_best  (cand_best)
	);

	// Saturating 48-bit accumulation of the finished job's times.
	assign tat_sum = {1'b0, sum_tat_q} + 49'(res_tat_q);
	assign wt_sum  = {1'b0, sum_wt_q} + 49'(res_wt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			slot_valid_q <= '0;
			time_now_q   <= '0;
			sum_tat_q    <= '0;
			sum_wt_q     <= '0;
			done_cnt_q   <= '0;
			rsp_valid_q  <= 1'b0;
			cmp_en_s1    <= 1'b0;
			best_q       <= '0;
		end else begin
			cmp_en_s1 <= (state_q == S_TSCAN);
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						idx_q        <= '0;
						best_q       <= '0;
						res_status_q <= srtf_pkg::ST_OK;
						if (req.func == srtf_pkg::FUNC_TICK) begin
							state_q <= S_TSCAN;
						end else if (req.burst == 16'd0) begin
							res_status_q <= srtf_pkg::ST_ZERO;
							state_q      <= S_RESULT;
						end else begin
							state_q <= S_ASCAN;
						end
					end
				end
				S_ASCAN: begin
					if (slot_free) begin
						slot_valid_q[idx_q] <= 1'b1;
						state_q             <= S_RESULT;
					end else if (idx_q == LAST_IDX) begin
						res_status_q <= srtf_pkg::ST_FULL;
						state_q      <= S_RESULT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_TSCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= S_TLAST;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_TLAST: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					time_now_q <= time_now_q + 32'd1;
					if (!best_q.found) begin
						res_status_q <= srtf_pkg::ST_IDLE_TICK;
						state_q      <= S_RESULT;
					end else if (best_q.rem == 16'd1) begin
						slot_valid_q[best_idx_q] <= 1'b0;
						state_q                  <= S_CALC;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_CALC: begin
					state_q <= S_ACCUM;
				end
				S_ACCUM: begin
					sum_tat_q <= tat_sum[48] ? '1 : tat_sum[47:0];
					sum_wt_q  <= wt_sum[48] ? '1 : wt_sum[47:0];
					if (done_cnt_q != 16'hFFFF) begin
						done_cnt_q <= done_cnt_q + 16'd1;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Fold each read slot into the running best as its data returns.
			if (take) begin
				best_q <= cand_best;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		vld_s1 <= slot_valid_q[idx_q];
		idx_s1 <= idx_q;
		if (take) begin
			best_idx_q   <= idx_s1;
			best_burst_q <= rd_entry.burst;
			best_stamp_q <= rd_entry.stamp;
		end
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					burst_q    <= req.burst;
					res_slot_q <= '0;
					res_ran_q  <= 1'b0;
					res_fin_q  <= 1'b0;
					res_tat_q  <= '0;
					res_wt_q   <= '0;
				end
			end
			S_ASCAN: begin
				if (slot_free) begin
					res_slot_q <= idx_q;
				end
			end
			S_UPDATE: begin
				res_ran_q <= best_q.found;
				// Stored remaining time is at least one while a slot is valid.
				res_fin_q <= best_q.found && (best_q.rem == 16'd1);
				res_tat_q <= time_now_q + 32'd1 - best_stamp_q;
				if (best_q.found) begin
					res_slot_q <= best_idx_q;
				end
			end
			S_CALC: begin
				res_wt_q <= res_tat_q - 32'(best_burst_q);
			end
			S_RESULT: begin
				if (rsp_load) begin
					rsp_q.status           <= res_status_q;
					rsp_q.job_slot         <= 5'(res_slot_q);
					rsp_q.ran              <= res_ran_q;
					rsp_q.finished         <= res_fin_q;
					rsp_q.current_time     <= time_now_q;
					rsp_q.turnaround       <= res_fin_q ? res_tat_q : 32'd0;
					rsp_q.waiting          <= res_fin_q ? res_wt_q : 32'd0;
					rsp_q.total_turnaround <= sum_tat_q;
					rsp_q.total_waiting    <= sum_wt_q;
					rsp_q.completed_count  <= done_cnt_q;
				end
			end
			default: begin
				res_slot_q <= res_slot_q;
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A finished job must be a job that ran, reported with status ok.
	`SRTF_ASSERT_NOW(a_fin_ran, clk, arst_n, rsp_valid && rsp.finished, rsp.ran && (rsp.status == srtf_pkg::ST_OK), "finished job reported without running")
	// An accepted tick starts the selection scan.
	`SRTF_ASSERT_NEXT(a_tick_scan, clk, arst_n, req_valid && !req_stall && (req.func == srtf_pkg::FUNC_TICK), state_q == S_TSCAN, "tick did not start a scan")
	// Every tick advances time by exactly one unit.
	`SRTF_ASSERT_NEXT(a_time_step, clk, arst_n, state_q == S_UPDATE, time_now_q == $past(time_now_q) + 32'd1, "time did not advance by one")
	// The job memory is never written while a scan reads it.
	`SRTF_ASSERT_NOW(a_no_wr_scan, clk, arst_n, ram_we, (state_q != S_TSCAN) && (state_q != S_TLAST), "job memory written during scan")

endmodule
